// ===== design/wmfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wmfe_pkg;

    // Body byte accounting. The count saturates at the smaller of the body
    // limit and what the 12-bit count can show.
    localparam int MAX_BODY_BYTES = 2048;
    localparam int USED_LIMIT_INT = (MAX_BODY_BYTES > 4095) ? 4095 : MAX_BODY_BYTES;
    localparam logic [11:0] USED_LIMIT = 12'(USED_LIMIT_INT);

    // Longest step list of any subtype.
    localparam int NSTEPS = 10;

    typedef logic [7:0] t_step_code;
    typedef logic [3:0] t_step_idx;
    typedef t_step_code [NSTEPS-1:0] t_step_row;

    // Step codes. An element step sets the top bit and carries its ID below it.
    localparam t_step_code K_END   = 8'h00;
    localparam t_step_code K_TS    = 8'h01;
    localparam t_step_code K_PLAIN = 8'h02;
    localparam t_step_code K_STAT  = 8'h03;
    localparam t_step_code K_AID   = 8'h04;
    localparam t_step_code K_AUTH  = 8'h05;
    localparam t_step_code K_AP    = 8'h06;
    localparam t_step_code K_ELEM  = 8'h80;

    // Management subtypes.
    localparam logic [3:0] SUB_ASSOC_REQ    = 4'd0;
    localparam logic [3:0] SUB_ASSOC_RESP   = 4'd1;
    localparam logic [3:0] SUB_REASSOC_REQ  = 4'd2;
    localparam logic [3:0] SUB_REASSOC_RESP = 4'd3;
    localparam logic [3:0] SUB_PROBE_REQ    = 4'd4;
    localparam logic [3:0] SUB_PROBE_RESP   = 4'd5;
    localparam logic [3:0] SUB_BEACON       = 4'd8;
    localparam logic [3:0] SUB_DISASSOC     = 4'd10;
    localparam logic [3:0] SUB_AUTH         = 4'd11;
    localparam logic [3:0] SUB_DEAUTH       = 4'd12;

    // Element IDs.
    localparam logic [6:0] EID_SSID      = 7'd0;
    localparam logic [6:0] EID_RATES     = 7'd1;
    localparam logic [6:0] EID_FH_PARAM  = 7'd2;
    localparam logic [6:0] EID_DS_PARAM  = 7'd3;
    localparam logic [6:0] EID_CF_PARAM  = 7'd4;
    localparam logic [6:0] EID_TIM       = 7'd5;
    localparam logic [6:0] EID_IBSS      = 7'd6;
    localparam logic [6:0] EID_CHALLENGE = 7'd16;

    // Bits of the seen flags.
    localparam int SEEN_STATUS = 0;
    localparam int SEEN_AID    = 1;
    localparam int SEEN_AUTH   = 2;

    typedef struct packed {
        logic [11:0] bytes_used;
        logic [15:0] status_value;
        logic        status_seen;
        logic [15:0] assoc_id;
        logic        assoc_id_seen;
        logic [15:0] auth_algorithm;
        logic        auth_seen;
        logic [8:0]  ssid_length;
        logic        underflow;
    } t_result;

    function automatic t_step_code elem(input logic [6:0] id);
        return K_ELEM | {1'b0, id};
    endfunction

    function automatic t_step_row step_row(input logic [3:0] sub);
        t_step_row row;
        row = {NSTEPS{K_END}};
        unique case (sub)
            SUB_ASSOC_REQ: begin
                row[0] = K_PLAIN;
                row[1] = K_PLAIN;
                row[2] = elem(EID_SSID);
                row[3] = elem(EID_RATES);
            end
            SUB_ASSOC_RESP, SUB_REASSOC_RESP: begin
                row[0] = K_PLAIN;
                row[1] = K_STAT;
                row[2] = K_AID;
                row[3] = elem(EID_RATES);
            end
            SUB_REASSOC_REQ: begin
                row[0] = K_PLAIN;
                row[1] = K_PLAIN;
                row[2] = K_AP;
                row[3] = elem(EID_SSID);
                row[4] = elem(EID_RATES);
            end
            SUB_PROBE_REQ: begin
                row[0] = elem(EID_SSID);
                row[1] = elem(EID_RATES);
            end
            SUB_PROBE_RESP, SUB_BEACON: begin
                row[0] = K_TS;
                row[1] = K_PLAIN;
                row[2] = K_PLAIN;
                row[3] = elem(EID_SSID);
                row[4] = elem(EID_RATES);
                row[5] = elem(EID_FH_PARAM);
                row[6] = elem(EID_DS_PARAM);
                row[7] = elem(EID_CF_PARAM);
                row[8] = elem(EID_IBSS);
                if (sub == SUB_BEACON) begin
                    row[9] = elem(EID_TIM);
                end
            end
            SUB_DISASSOC, SUB_DEAUTH: begin
                row[0] = K_STAT;
            end
            SUB_AUTH: begin
                row[0] = K_AUTH;
                row[1] = K_PLAIN;
                row[2] = K_STAT;
                row[3] = elem(EID_CHALLENGE);
            end
            default: begin
                row = {NSTEPS{K_END}};
            end
        endcase
        return row;
    endfunction

    function automatic t_step_code code_at(input t_step_row row, input t_step_idx idx);
        t_step_code code;
        if (idx >= t_step_idx'(NSTEPS)) begin
            code = K_END;
        end else begin
            code = row[idx];
        end
        return code;
    endfunction

    function automatic logic [3:0] fixed_size(input t_step_code code);
        logic [3:0] size;
        if (code == K_TS) begin
            size = 4'd8;
        end else if (code == K_AP) begin
            size = 4'd6;
        end else begin
            size = 4'd2;
        end
        return size;
    endfunction

endpackage

`default_nettype wire

// ===== design/wmfe_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface wmfe_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] frame_subtype;
    logic [7:0] body_byte;
    logic       byte_valid;
    logic       body_last;

    modport source (output valid, output frame_subtype, output body_byte,
                    output byte_valid, output body_last, input ready);
    modport sink   (input valid, input frame_subtype, input body_byte,
                    input byte_valid, input body_last, output ready);
endinterface

interface wmfe_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] bytes_used;
    logic [15:0] status_value;
    logic        status_seen;
    logic [15:0] assoc_id;
    logic        assoc_id_seen;
    logic [15:0] auth_algorithm;
    logic        auth_seen;
    logic [8:0]  ssid_length;
    logic        underflow;

    modport source (output valid, output bytes_used, output status_value,
                    output status_seen, output assoc_id, output assoc_id_seen,
                    output auth_algorithm, output auth_seen, output ssid_length,
                    output underflow, input ready);
    modport sink   (input valid, input bytes_used, input status_value,
                    input status_seen, input assoc_id, input assoc_id_seen,
                    input auth_algorithm, input auth_seen, input ssid_length,
                    input underflow, output ready);
endinterface

`default_nettype wire

// ===== design/wlan_mgmt_body_field_extractor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Management frame body parser. Each transfer on the input channel carries
// one body byte with the frame subtype; the transfer marked body_last closes
// the body and produces one result transfer with the byte count, status or
// reason code, AID, authentication algorithm, SSID length and an underflow
// flag. The block takes one input transfer every cycle while ready is high:
// the step search, the field capture and the byte count are all combinational
// logic between the parse state registers, and a body's result is registered
// into the output register, or into the skid register while the output is
// stalled. Results pass through a two-entry buffer (output register plus skid
// register), so input keeps flowing while one result waits; input is held off
// only when both entries are occupied. The byte count saturates at
// BODY_BYTES_MAX, or at 4095 where that is larger. Configuration is fixed;
// there is no register port.
module wlan_mgmt_body_field_extractor
    import wmfe_pkg::*;
#(
    parameter int BODY_BYTES_MAX = MAX_BODY_BYTES
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    wmfe_in_if.sink         i_in,
    wmfe_out_if.source      o_out
);

    // Saturation point of the byte count.
    localparam logic [11:0] USED_CAP =
        (BODY_BYTES_MAX > 4095) ? 12'd4095 : 12'(BODY_BYTES_MAX);

    // Parse state.
    t_step_idx   r_step_index;
    logic [3:0]  r_field_byte_count;
    logic [7:0]  r_element_length;
    logic [15:0] r_field_accumulator;
    logic [11:0] r_used_count;
    logic [15:0] r_captured_status;
    logic [15:0] r_captured_aid;
    logic [15:0] r_captured_auth;
    logic [8:0]  r_captured_ssid_length;
    logic [2:0]  r_seen_flags;
    logic        r_parse_stopped;

    t_step_idx   n_step_index;
    logic [3:0]  n_field_byte_count;
    logic [7:0]  n_element_length;
    logic [15:0] n_field_accumulator;
    logic [11:0] n_used_count;
    logic [15:0] n_captured_status;
    logic [15:0] n_captured_aid;
    logic [15:0] n_captured_auth;
    logic [8:0]  n_captured_ssid_length;
    logic [2:0]  n_seen_flags;
    logic        n_parse_stopped;

    // Result buffering.
    t_result     r_out;
    logic        r_out_valid;
    t_result     r_skid;
    logic        r_skid_valid;

    logic        w_accept;
    logic        w_push;
    logic        w_pop;

    t_step_row   w_row;
    logic [NSTEPS-1:0] w_hit;
    t_step_idx   w_sel_idx;
    logic        w_sel_found;
    t_step_code  w_sel_code;
    logic        w_moved;

    logic [3:0]  w_fbc;
    logic [7:0]  w_elen;
    logic [15:0] w_acc;
    logic [15:0] w_acc_new;
    logic [3:0]  w_fbc_inc;
    logic [7:0]  w_elen_dec;
    logic        w_done;
    logic [16:0] w_add;
    logic [17:0] w_used_sum;

    t_step_code  w_end_code;
    logic        w_underflow;
    t_result     w_result;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_push   = w_accept && i_in.body_last;
    assign w_pop    = r_out_valid && o_out.ready;

    assign i_in.ready = !r_skid_valid;

    // Step search. A mismatching element that has not started yet is skipped
    // without using the byte, so the byte lands on the first later step that
    // is a fixed field, the end of the list, or an element with that ID.
    // A step already in progress always keeps the byte.
    always_comb begin
        w_row = step_row(i_in.frame_subtype);
        for (int p = 0; p < NSTEPS; p++) begin
            w_hit[p] = ((4'(p) == r_step_index) && (r_field_byte_count != '0))
                    || ((4'(p) >= r_step_index)
                        && ((w_row[p] == K_END) || !w_row[p][7]
                            || (i_in.body_byte == {1'b0, w_row[p][6:0]})));
        end
        w_sel_idx   = 4'(NSTEPS);
        w_sel_found = 1'b0;
        for (int p = 0; p < NSTEPS; p++) begin
            if (w_hit[p] && !w_sel_found) begin
                w_sel_idx   = 4'(p);
                w_sel_found = 1'b1;
            end
        end
        w_sel_code = code_at(w_row, w_sel_idx);
        w_moved    = (w_sel_idx != r_step_index);
        // Skipped steps leave freshly cleared field state behind them.
        w_fbc  = w_moved ? 4'd0  : r_field_byte_count;
        w_elen = w_moved ? 8'd0  : r_element_length;
        w_acc  = w_moved ? 16'd0 : r_field_accumulator;
    end

    // Byte consumption on the selected step.
    always_comb begin
        n_step_index           = r_step_index;
        n_field_byte_count     = r_field_byte_count;
        n_element_length       = r_element_length;
        n_field_accumulator    = r_field_accumulator;
        n_captured_status      = r_captured_status;
        n_captured_aid         = r_captured_aid;
        n_captured_auth        = r_captured_auth;
        n_captured_ssid_length = r_captured_ssid_length;
        n_seen_flags           = r_seen_flags;
        n_parse_stopped        = r_parse_stopped;

        w_acc_new  = w_acc;
        w_fbc_inc  = w_fbc + 4'd1;
        w_elen_dec = (w_elen != 8'd0) ? (w_elen - 8'd1) : 8'd0;
        w_done     = 1'b0;
        w_add      = '0;

        if (i_in.byte_valid && !r_parse_stopped) begin
            n_step_index        = w_sel_idx;
            n_field_byte_count  = w_fbc;
            n_element_length    = w_elen;
            n_field_accumulator = w_acc;

            if (w_sel_code == K_END) begin
                n_parse_stopped = 1'b1;
            end else if (!w_sel_code[7]) begin
                // Fixed field: little-endian, only the first two bytes kept.
                if (w_fbc == 4'd0) begin
                    w_acc_new = {8'h00, i_in.body_byte};
                end else if (w_fbc == 4'd1) begin
                    w_acc_new = w_acc | {i_in.body_byte, 8'h00};
                end
                n_field_accumulator = w_acc_new;
                n_field_byte_count  = w_fbc_inc;
                if (w_fbc_inc >= fixed_size(w_sel_code)) begin
                    w_done = 1'b1;
                    w_add  = 17'(fixed_size(w_sel_code));
                    priority if (w_sel_code == K_STAT) begin
                        n_captured_status         = w_acc_new;
                        n_seen_flags[SEEN_STATUS] = 1'b1;
                    end else if (w_sel_code == K_AID) begin
                        n_captured_aid         = w_acc_new;
                        n_seen_flags[SEEN_AID] = 1'b1;
                    end else if (w_sel_code == K_AUTH) begin
                        n_captured_auth         = w_acc_new;
                        n_seen_flags[SEEN_AUTH] = 1'b1;
                    end else begin
                        n_seen_flags = r_seen_flags;
                    end
                end
            end else begin
                // Element: ID byte, length byte, then the info bytes.
                if (w_fbc == 4'd0) begin
                    n_field_byte_count = 4'd1;
                end else if (w_fbc == 4'd1) begin
                    w_acc_new           = {8'h00, i_in.body_byte};
                    n_field_accumulator = w_acc_new;
                    n_element_length    = i_in.body_byte;
                    n_field_byte_count  = 4'd2;
                    w_done              = (i_in.body_byte == 8'd0);
                end else begin
                    n_element_length = w_elen_dec;
                    w_done           = (w_elen_dec == 8'd0);
                end
                if (w_done) begin
                    if (w_sel_code[6:0] == EID_SSID) begin
                        n_captured_ssid_length = 9'(17'(w_acc_new) + 17'd1);
                    end
                    w_add = 17'(w_acc_new) + 17'd2;
                end
            end

            if (w_done) begin
                n_step_index        = w_sel_idx + 4'd1;
                n_field_byte_count  = '0;
                n_element_length    = '0;
                n_field_accumulator = '0;
            end
        end

        w_used_sum = 18'(r_used_count) + 18'(w_add);
        if (w_done) begin
            n_used_count = (w_used_sum > 18'(USED_CAP)) ? USED_CAP : w_used_sum[11:0];
        end else begin
            n_used_count = r_used_count;
        end
    end

    // The body is short if it stops inside a field or element, or just
    // before a fixed field that is still due. An element not yet begun is
    // simply absent.
    always_comb begin
        w_end_code  = code_at(w_row, n_step_index);
        w_underflow = !n_parse_stopped && (w_end_code != K_END)
                   && (!w_end_code[7] || (n_field_byte_count != 4'd0));

        w_result.bytes_used     = n_used_count;
        w_result.status_value   = n_captured_status;
        w_result.status_seen    = n_seen_flags[SEEN_STATUS];
        w_result.assoc_id       = n_captured_aid;
        w_result.assoc_id_seen  = n_seen_flags[SEEN_AID];
        w_result.auth_algorithm = n_captured_auth;
        w_result.auth_seen      = n_seen_flags[SEEN_AUTH];
        w_result.ssid_length    = n_captured_ssid_length;
        w_result.underflow      = w_underflow;
    end

    // Parse state clears after the last transfer of each body.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_push) begin
            r_step_index           <= '0;
            r_field_byte_count     <= '0;
            r_element_length       <= '0;
            r_field_accumulator    <= '0;
            r_used_count           <= '0;
            r_captured_status      <= '0;
            r_captured_aid         <= '0;
            r_captured_auth        <= '0;
            r_captured_ssid_length <= '0;
            r_seen_flags           <= '0;
            r_parse_stopped        <= 1'b0;
        end else if (w_accept) begin
            r_step_index           <= n_step_index;
            r_field_byte_count     <= n_field_byte_count;
            r_element_length       <= n_element_length;
            r_field_accumulator    <= n_field_accumulator;
            r_used_count           <= n_used_count;
            r_captured_status      <= n_captured_status;
            r_captured_aid         <= n_captured_aid;
            r_captured_auth        <= n_captured_auth;
            r_captured_ssid_length <= n_captured_ssid_length;
            r_seen_flags           <= n_seen_flags;
            r_parse_stopped        <= n_parse_stopped;
        end
    end

    // Result buffer control. The skid entry fills only when a new result
    // arrives while the output register is full and stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_pop) begin
                r_out <= r_skid;
            end
        end else if (w_push) begin
            if (!r_out_valid || w_pop) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.bytes_used     = r_out.bytes_used;
    assign o_out.status_value   = r_out.status_value;
    assign o_out.status_seen    = r_out.status_seen;
    assign o_out.assoc_id       = r_out.assoc_id;
    assign o_out.assoc_id_seen  = r_out.assoc_id_seen;
    assign o_out.auth_algorithm = r_out.auth_algorithm;
    assign o_out.auth_seen      = r_out.auth_seen;
    assign o_out.ssid_length    = r_out.ssid_length;
    assign o_out.underflow      = r_out.underflow;

    // The skid entry is only ever used behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds a result while the output register is empty");

    // A closed body leaves no parse state for the next one.
    a_body_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> (r_step_index == '0) && !r_parse_stopped
                   && (r_used_count == '0) && (r_seen_flags == '0)
                   && (r_field_byte_count == '0))
        else $error("parse state not cleared after the end of a body");

    a_used_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used_count <= USED_CAP)
        else $error("byte count above its saturation limit");

    // No field in progress is longer than the timestamp.
    a_field_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_byte_count <= 4'd8)
        else $error("field byte count out of range");

endmodule

`default_nettype wire
